// ===== rtl/gifl_pkg.sv =====
// shared types, codes and constants for the gtp-u inner frame locator
// used by the register file, the parser, the top level and the testbench
package gifl_pkg;

	localparam int unsigned POS_W = 16;
	localparam int unsigned REG_W = 16;
	localparam int unsigned IDX_W = 2;

	localparam logic [POS_W-1:0] PKT_LEN_LIMIT = 16'hFFFF;

	// protocol constants
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
	localparam logic [3:0]  IP_VER_4      = 4'd4;
	localparam logic [3:0]  IP_VER_6      = 4'd6;
	localparam logic [3:0]  IP_IHL_MIN    = 4'd5;
	localparam logic [7:0]  GTP_VER_MASK  = 8'hF0;
	localparam logic [7:0]  GTP_V1_PT     = 8'h30;
	localparam logic [7:0]  MSG_TYPE_TPDU = 8'hFF;
	localparam logic [7:0]  GTP_E_FLAG    = 8'h04;
	localparam logic [7:0]  GTP_OPT_FLAGS = 8'h07;
	localparam logic [15:0] LO_BYTE_MASK  = 16'h00FF;
	localparam logic [15:0] HI_BYTE_MASK  = 16'hFF00;

	// byte offsets inside each header
	localparam logic [POS_W-1:0] REL_0  = 16'd0;
	localparam logic [POS_W-1:0] REL_1  = 16'd1;
	localparam logic [POS_W-1:0] REL_2  = 16'd2;
	localparam logic [POS_W-1:0] REL_3  = 16'd3;
	localparam logic [POS_W-1:0] REL_7  = 16'd7;
	localparam logic [POS_W-1:0] REL_9  = 16'd9;
	localparam logic [POS_W-1:0] REL_12 = 16'd12;
	localparam logic [POS_W-1:0] REL_13 = 16'd13;
	localparam logic [POS_W-1:0] REL_19 = 16'd19;

	typedef enum logic [IDX_W-1:0] {
		REG_GTPU_UDP_PORT = 2'd0,
		REG_VLAN_TPID_A   = 2'd1,
		REG_VLAN_TPID_B   = 2'd2,
		REG_VLAN_TPID_C   = 2'd3
	} reg_idx_t;

	localparam logic [REG_W-1:0] RST_GTPU_UDP_PORT = 16'd2152;
	localparam logic [REG_W-1:0] RST_VLAN_TPID_A   = 16'd33024;
	localparam logic [REG_W-1:0] RST_VLAN_TPID_B   = 16'd34984;
	localparam logic [REG_W-1:0] RST_VLAN_TPID_C   = 16'd37120;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_SHORT   = 2'd1,
		ST_NOTGTP  = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_ETH   = 4'd0,
		PH_VLAN  = 4'd1,
		PH_IP    = 4'd2,
		PH_UDP   = 4'd3,
		PH_GTP   = 4'd4,
		PH_OPT   = 4'd5,
		PH_EXT   = 4'd6,
		PH_INNER = 4'd7
	} phase_t;

	typedef struct packed {
		logic [REG_W-1:0] gtpu_udp_port;
		logic [REG_W-1:0] vlan_tpid_a;
		logic [REG_W-1:0] vlan_tpid_b;
		logic [REG_W-1:0] vlan_tpid_c;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [POS_W-1:0] offset;
	} res_t;

	// clamp a layer start position to the length limit
	function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] p);
		return (p > {1'b0, PKT_LEN_LIMIT}) ? PKT_LEN_LIMIT : p[POS_W-1:0];
	endfunction

endpackage

// ===== rtl/gifl_if.sv =====
// valid/ready channel interfaces for frame words and result words
// no dependencies
interface gifl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface gifl_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  parse_status;
	logic [15:0] inner_offset;

	modport source(output valid, output parse_status, output inner_offset, input ready);
	modport sink(input valid, input parse_status, input inner_offset, output ready);
endinterface

// ===== rtl/gtpu_inner_frame_locator_top.sv =====
// gtp-u inner frame locator, top level
// depends on gifl_pkg, gifl_if, gifl_cfg_regs and gifl_parser
// usage:
//   byte_ch carries an ethernet frame one word per ready cycle (data_byte, with
//   last_byte on the final byte). result_ch returns one word per frame, at
//   its last byte: parse_status (0 valid gtp-u, 1 too short, 2 not gtp-u,
//   3 invalid) and inner_offset, the byte offset of the inner ip header
//   (zero unless the status is valid).
//   wr_en/wr_index/wr_data write the udp port and the three vlan tpids;
//   write them only while no frame is in flight.
// pipeline and throughput:
//   a byte is registered at acceptance and parsed from that register; the
//   result word is registered from the verdict on its last byte.
//   one byte is accepted every cycle while byte_ch.ready is high.
// reset:
//   arst_n clears the frame state and loads the default register values.
// stall:
//   while a result word waits, bytes keep flowing until a further last
//   byte reaches the parse stage; then byte_ch.ready drops until the
//   waiting word is taken.
module gtpu_inner_frame_locator_top (
	input  logic                       clk,
	input  logic                       arst_n,
	gifl_byte_if.sink                  byte_ch,
	gifl_result_if.source              result_ch,
	input  logic                       wr_en,
	input  logic [gifl_pkg::IDX_W-1:0] wr_index,
	input  logic [gifl_pkg::REG_W-1:0] wr_data
);
	import gifl_pkg::*;

	cfg_t       cfg;
	res_t       res;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance;
	logic       take_in;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [POS_W-1:0]  out_offset_q;

	// a last byte may only be parsed when the result register can take it
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;
	assign take_in = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1 <= byte_ch.data_byte;
			last_s1 <= byte_ch.last_byte;
		end
	end

	gifl_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	gifl_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_status_q <= res.status;
			out_offset_q <= res.offset;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.parse_status = out_status_q;
	assign result_ch.inner_offset = out_offset_q;

endmodule

// ===== rtl/gifl_cfg_regs.sv =====
// configuration registers: udp port and three vlan tpids
// depends on gifl_pkg
module gifl_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [gifl_pkg::IDX_W-1:0]   wr_index,
	input  logic [gifl_pkg::REG_W-1:0]   wr_data,
	output gifl_pkg::cfg_t               cfg
);
	import gifl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gtpu_udp_port <= RST_GTPU_UDP_PORT;
			cfg_q.vlan_tpid_a   <= RST_VLAN_TPID_A;
			cfg_q.vlan_tpid_b   <= RST_VLAN_TPID_B;
			cfg_q.vlan_tpid_c   <= RST_VLAN_TPID_C;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_GTPU_UDP_PORT: cfg_q.gtpu_udp_port <= wr_data;
				REG_VLAN_TPID_A:   cfg_q.vlan_tpid_a   <= wr_data;
				REG_VLAN_TPID_B:   cfg_q.vlan_tpid_b   <= wr_data;
				REG_VLAN_TPID_C:   cfg_q.vlan_tpid_c   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/gifl_parser.sv =====
// per-frame header walk: one byte per step, verdict on the last byte
// depends on gifl_pkg
module gifl_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     data_byte,
	input  logic           last_byte,
	input  gifl_pkg::cfg_t cfg,
	output gifl_pkg::res_t res
);
	import gifl_pkg::*;

	logic [POS_W-1:0] pos_q, nfp_q, acc_q;
	phase_t           phase_q;
	logic             match_q, final_q;
	logic [7:0]       flags_q;
	status_t          verdict_q;

	// state after this byte is parsed, before the end-of-frame clear
	logic [POS_W-1:0] pos_p, nfp_p, acc_p;
	phase_t           phase_p;
	logic             match_p, final_p;
	logic [7:0]       flags_p;
	status_t          verdict_p;

	logic [POS_W-1:0] rel;
	logic [POS_W-1:0] word;
	logic [POS_W-1:0] base_next;
	logic [POS_W-1:0] base_udp;
	logic [POS_W+1:0] ext_end;
	logic             tpid_hit;

	assign rel       = pos_q - nfp_q;
	assign word      = acc_q | {8'h00, data_byte};
	assign base_next = sat_pos({1'b0, pos_q} + 17'd1);
	assign base_udp  = sat_pos({1'b0, nfp_q} + {11'd0, acc_q[3:0], 2'b00});
	assign ext_end   = {acc_q, 2'b00} - 18'd1;
	assign tpid_hit  = (word == cfg.vlan_tpid_a) || (word == cfg.vlan_tpid_b)
		|| (word == cfg.vlan_tpid_c);

	always_comb begin
		pos_p     = pos_q;
		nfp_p     = nfp_q;
		acc_p     = acc_q;
		phase_p   = phase_q;
		match_p   = match_q;
		final_p   = final_q;
		flags_p   = flags_q;
		verdict_p = verdict_q;
		if (pos_q != PKT_LEN_LIMIT) begin
			pos_p = pos_q + 16'd1;
			if (!final_q && pos_q >= nfp_q) begin
				case (phase_q)
					PH_ETH, PH_VLAN: begin
						if (phase_q == PH_VLAN && rel == REL_0) begin
							verdict_p = ST_SHORT;
						end else if ((phase_q == PH_ETH && rel == REL_12)
							|| (phase_q == PH_VLAN && rel == REL_2)) begin
							acc_p = {data_byte, 8'h00};
						end else if ((phase_q == PH_ETH && rel == REL_13)
							|| (phase_q == PH_VLAN && rel == REL_3)) begin
							// ethertype complete
							if (tpid_hit) begin
								phase_p   = PH_VLAN;
								nfp_p     = base_next;
								verdict_p = ST_NOTGTP;
							end else if (word == ETH_TYPE_IPV4) begin
								phase_p = PH_IP;
								nfp_p   = base_next;
							end else begin
								verdict_p = ST_NOTGTP;
								final_p   = 1'b1;
							end
						end
					end
					PH_IP: begin
						if (rel == REL_0) begin
							acc_p = {8'h00, data_byte};
						end else if (rel == REL_9) begin
							acc_p = (acc_q & LO_BYTE_MASK) | {data_byte, 8'h00};
						end else if (rel == REL_19) begin
							if (acc_q[7:4] != IP_VER_4 || acc_q[3:0] < IP_IHL_MIN) begin
								verdict_p = ST_INVALID;
								final_p   = 1'b1;
							end else if (((acc_q & HI_BYTE_MASK) >> 8) != {8'h00, IP_PROTO_UDP}) begin
								verdict_p = ST_NOTGTP;
								final_p   = 1'b1;
							end else begin
								phase_p = PH_UDP;
								nfp_p   = base_udp;
							end
						end
					end
					PH_UDP: begin
						if (rel == REL_0 || rel == REL_2) begin
							acc_p = {data_byte, 8'h00};
						end else if (rel == REL_1 || rel == REL_3) begin
							if (word == cfg.gtpu_udp_port) begin
								match_p = 1'b1;
							end
						end else if (rel == REL_7) begin
							if (!match_q) begin
								verdict_p = ST_NOTGTP;
								final_p   = 1'b1;
							end else begin
								phase_p = PH_GTP;
								nfp_p   = base_next;
							end
						end
					end
					PH_GTP: begin
						if (rel == REL_0) begin
							flags_p = data_byte;
						end else if (rel == REL_1) begin
							acc_p = {8'h00, data_byte};
						end else if (rel == REL_7) begin
							if ((flags_q & GTP_VER_MASK) != GTP_V1_PT
								|| acc_q != {8'h00, MSG_TYPE_TPDU}) begin
								verdict_p = ST_NOTGTP;
								final_p   = 1'b1;
							end else if ((flags_q & GTP_OPT_FLAGS) != 8'h00) begin
								phase_p = PH_OPT;
								nfp_p   = base_next;
							end else begin
								phase_p = PH_INNER;
								nfp_p   = base_next;
							end
						end
					end
					PH_OPT: begin
						// last byte of the optional field is the first extension type
						if (rel == REL_3) begin
							nfp_p = base_next;
							if ((flags_q & GTP_E_FLAG) != 8'h00 && data_byte != 8'h00) begin
								phase_p = PH_EXT;
							end else begin
								phase_p = PH_INNER;
							end
						end
					end
					PH_EXT: begin
						if (rel == REL_0) begin
							if (data_byte == 8'h00) begin
								phase_p = PH_INNER;
								nfp_p   = base_next;
							end else begin
								acc_p = {8'h00, data_byte};
							end
						end else if ({2'b00, rel} == ext_end) begin
							// next extension type
							nfp_p = base_next;
							if (data_byte != 8'h00) begin
								phase_p = PH_EXT;
							end else begin
								phase_p = PH_INNER;
							end
						end
					end
					PH_INNER: begin
						if (rel == REL_0) begin
							acc_p = {8'h00, data_byte};
						end else if (rel == REL_19) begin
							final_p   = 1'b1;
							verdict_p = (acc_q[7:4] == IP_VER_4 || acc_q[7:4] == IP_VER_6)
								? ST_VALID : ST_INVALID;
						end
					end
					default: begin
						verdict_p = ST_INVALID;
						final_p   = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		res.valid  = step && last_byte;
		res.status = verdict_p;
		res.offset = (final_p && verdict_p == ST_VALID) ? nfp_p : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			nfp_q     <= '0;
			acc_q     <= '0;
			phase_q   <= PH_ETH;
			match_q   <= 1'b0;
			final_q   <= 1'b0;
			flags_q   <= '0;
			verdict_q <= ST_SHORT;
		end else if (step) begin
			if (last_byte) begin
				pos_q     <= '0;
				nfp_q     <= '0;
				acc_q     <= '0;
				phase_q   <= PH_ETH;
				match_q   <= 1'b0;
				final_q   <= 1'b0;
				flags_q   <= '0;
				verdict_q <= ST_SHORT;
			end else begin
				pos_q     <= pos_p;
				nfp_q     <= nfp_p;
				acc_q     <= acc_p;
				phase_q   <= phase_p;
				match_q   <= match_p;
				final_q   <= final_p;
				flags_q   <= flags_p;
				verdict_q <= verdict_p;
			end
		end
	end

endmodule

// ===== test/tb_gtpu_inner_frame_locator_top.sv =====
`timescale 1ns / 100ps
// testbench for gtpu_inner_frame_locator_top: directed and random ethernet frames,
// each byte fed to a header-walk model that predicts the status and offset word.
// depends on gifl_pkg, gifl_if and the rtl of the block
module tb_gtpu_inner_frame_locator_top;
	import gifl_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	typedef struct {
		status_t     status;
		logic [15:0] offset;
	} frame_verdict_t;

	typedef struct {
		int          noise_len;
		int          noise_fill;
		int          vlan_tags;
		logic [15:0] ethertype;
		logic [7:0]  ver_ihl;
		logic [7:0]  proto;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  gtp_flags;
		logic [7:0]  gtp_msg;
		logic [7:0]  ext_next;
		int          ext_count;
		int          ext_words;
		bit          ext_zero_end;
		logic [7:0]  inner_first;
		int          payload_len;
		int          cut_len;
		int          flip_at;
	} frame_spec_t;

	// walks the headers byte by byte and keeps the verdicts still owed by the block
	class verdict_tracker;
		cfg_t           regs;
		logic [15:0]    byte_pos;
		logic [15:0]    layer_start;
		logic [15:0]    acc;
		logic [7:0]     gflags;
		phase_t         phase;
		bit             port_hit;
		bit             locked;
		status_t        verdict;
		frame_verdict_t verdicts_due[$];
		int             errors;

		function new();
			regs = '{RST_GTPU_UDP_PORT, RST_VLAN_TPID_A, RST_VLAN_TPID_B, RST_VLAN_TPID_C};
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			byte_pos = '0;
			layer_start = '0;
			acc = '0;
			gflags = '0;
			phase = PH_ETH;
			port_hit = 1'b0;
			locked = 1'b0;
			verdict = ST_SHORT;
		endfunction

		function void lock(status_t s);
			verdict = s;
			locked = 1'b1;
		endfunction

		function void open_layer(phase_t p, logic [16:0] base);
			phase = p;
			layer_start = (base > {1'b0, PKT_LEN_LIMIT}) ? PKT_LEN_LIMIT : base[15:0];
		endfunction

		function void ethertype_check(logic [15:0] et, logic [15:0] pos);
			if (et == regs.vlan_tpid_a || et == regs.vlan_tpid_b || et == regs.vlan_tpid_c) begin
				open_layer(PH_VLAN, {1'b0, pos} + 17'd1);
				// a frame that stops right here is reported as not gtp-u
				verdict = ST_NOTGTP;
			end else if (et == ETH_TYPE_IPV4) begin
				open_layer(PH_IP, {1'b0, pos} + 17'd1);
			end else begin
				lock(ST_NOTGTP);
			end
		endfunction

		function void walk_byte(logic [7:0] b, logic [15:0] pos);
			logic [15:0] rel;
			logic [16:0] next_pos;
			if (pos < layer_start)
				return;
			rel = pos - layer_start;
			next_pos = {1'b0, pos} + 17'd1;
			case (phase)
				PH_ETH: begin
					if (rel == 12) acc = {b, 8'h00};
					else if (rel == 13) ethertype_check(acc | b, pos);
				end
				PH_VLAN: begin
					if (rel == 0) verdict = ST_SHORT;
					else if (rel == 2) acc = {b, 8'h00};
					else if (rel == 3) ethertype_check(acc | b, pos);
				end
				PH_IP: begin
					if (rel == 0) begin
						acc = {8'h00, b};
					end else if (rel == 9) begin
						acc = {b, acc[7:0]};
					end else if (rel == 19) begin
						// version and ihl sit in the low half, protocol in the high half
						if (acc[7:4] != IP_VER_4 || acc[3:0] < IP_IHL_MIN)
							lock(ST_INVALID);
						else if (acc[15:8] != IP_PROTO_UDP)
							lock(ST_NOTGTP);
						else
							open_layer(PH_UDP, {1'b0, layer_start} + {11'd0, acc[3:0], 2'b00});
					end
				end
				PH_UDP: begin
					if (rel == 0 || rel == 2) begin
						acc = {b, 8'h00};
					end else if (rel == 1 || rel == 3) begin
						if ((acc | b) == regs.gtpu_udp_port) port_hit = 1'b1;
					end else if (rel == 7) begin
						if (!port_hit) lock(ST_NOTGTP);
						else open_layer(PH_GTP, next_pos);
					end
				end
				PH_GTP: begin
					if (rel == 0) begin
						gflags = b;
					end else if (rel == 1) begin
						acc = {8'h00, b};
					end else if (rel == 7) begin
						if ((gflags & GTP_VER_MASK) != GTP_V1_PT || acc != {8'h00, MSG_TYPE_TPDU})
							lock(ST_NOTGTP);
						else if ((gflags & GTP_OPT_FLAGS) != 0)
							open_layer(PH_OPT, next_pos);
						else
							open_layer(PH_INNER, next_pos);
					end
				end
				PH_OPT: begin
					if (rel == 3) begin
						// the next-type byte only counts when the e flag is set
						if ((gflags & GTP_E_FLAG) != 0 && b != 0) open_layer(PH_EXT, next_pos);
						else open_layer(PH_INNER, next_pos);
					end
				end
				PH_EXT: begin
					if (rel == 0) begin
						if (b == 0) open_layer(PH_INNER, next_pos);
						else acc = {8'h00, b};
					end else if (rel == {acc, 2'b00} - 1) begin
						if (b != 0) open_layer(PH_EXT, next_pos);
						else open_layer(PH_INNER, next_pos);
					end
				end
				PH_INNER: begin
					if (rel == 0) begin
						acc = {8'h00, b};
					end else if (rel == 19) begin
						if (acc[7:4] == IP_VER_4 || acc[7:4] == IP_VER_6) lock(ST_VALID);
						else lock(ST_INVALID);
					end
				end
				default: lock(ST_INVALID);
			endcase
		endfunction

		function void take_word(logic [7:0] b, logic fin);
			frame_verdict_t v;
			if (byte_pos < PKT_LEN_LIMIT) begin
				if (!locked) walk_byte(b, byte_pos);
				byte_pos = byte_pos + 16'd1;
			end
			if (fin) begin
				v.status = verdict;
				v.offset = (locked && verdict == ST_VALID) ? layer_start : 16'd0;
				verdicts_due.push_back(v);
				clear_frame();
			end
		endfunction

		function void check_word(logic [1:0] st, logic [15:0] off);
			frame_verdict_t v;
			if (verdicts_due.size() == 0) begin
				$error("result word with no frame pending: parse_status %0d inner_offset %0d",
					st, off);
				errors++;
				return;
			end
			v = verdicts_due.pop_front();
			if (st !== v.status) begin
				$error("parse_status: expected %0d, actual %0d", v.status, st);
				errors++;
			end
			if (off !== v.offset) begin
				$error("inner_offset: expected %0d, actual %0d", v.offset, off);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_index;
	logic [REG_W-1:0]    wr_data;
	bit                  idling;
	bit                  final_stretch;
	int unsigned         cycles;
	logic [7:0]          frame_bytes[$];
	verdict_tracker      tracker = new();

	gifl_byte_if   byte_ch();
	gifl_result_if result_ch();

	gtpu_inner_frame_locator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles == CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// result side stalls
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (idling && $urandom_range(0, 15) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			tracker.check_word(result_ch.parse_status, result_ch.inner_offset);
	end

	function automatic void push_rand(int n);
		repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void push16(logic [15:0] v);
		frame_bytes.push_back(v[15:8]);
		frame_bytes.push_back(v[7:0]);
	endfunction

	function automatic frame_spec_t well_formed();
		frame_spec_t s;
		s.noise_len = 0;
		s.noise_fill = -1;
		s.vlan_tags = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		s.ethertype = ETH_TYPE_IPV4;
		s.ver_ihl = {IP_VER_4, ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : IP_IHL_MIN};
		s.proto = IP_PROTO_UDP;
		if ($urandom_range(0, 1)) begin
			s.src_port = tracker.regs.gtpu_udp_port;
			s.dst_port = 16'($urandom);
		end else begin
			s.src_port = 16'($urandom);
			s.dst_port = tracker.regs.gtpu_udp_port;
		end
		s.gtp_flags = {GTP_V1_PT[7:4], 4'($urandom_range(0, 15))};
		s.gtp_msg = MSG_TYPE_TPDU;
		s.ext_next = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
		s.ext_count = $urandom_range(0, 3);
		s.ext_words = 0;
		s.ext_zero_end = $urandom_range(0, 1);
		s.inner_first = {$urandom_range(0, 1) ? IP_VER_4 : IP_VER_6, 4'($urandom_range(0, 15))};
		s.payload_len = $urandom_range(0, 24);
		s.cut_len = 0;
		s.flip_at = -1;
		return s;
	endfunction

	// mostly clean frames, the rest with one broken field, a cut, a hit byte or plain noise
	function automatic frame_spec_t random_spec();
		frame_spec_t s;
		s = well_formed();
		case ($urandom_range(0, 27))
			0, 1: s.cut_len = $urandom_range(1, 90);
			2: s.flip_at = $urandom_range(0, 80);
			3: s.noise_len = $urandom_range(1, 60);
			4: s.ethertype = 16'($urandom);
			5: s.ver_ihl = 8'($urandom);
			6: s.proto = 8'($urandom);
			7: begin
				s.src_port = 16'($urandom);
				s.dst_port = 16'($urandom);
			end
			8: s.gtp_flags = 8'($urandom);
			9: s.gtp_msg = 8'($urandom);
			10: s.inner_first = 8'($urandom);
			11: s.ext_words = $urandom_range(1, 8);
			default: ;
		endcase
		return s;
	endfunction

	task automatic build_frame(input frame_spec_t s);
		logic [15:0] tpid;
		int          words;
		frame_bytes.delete();
		if (s.noise_len > 0) begin
			repeat (s.noise_len)
				frame_bytes.push_back((s.noise_fill < 0) ? 8'($urandom_range(0, 255)) : 8'(s.noise_fill));
			return;
		end
		push_rand(12);
		repeat (s.vlan_tags) begin
			case ($urandom_range(0, 2))
				0: tpid = tracker.regs.vlan_tpid_a;
				1: tpid = tracker.regs.vlan_tpid_b;
				default: tpid = tracker.regs.vlan_tpid_c;
			endcase
			push16(tpid);
			push_rand(2);
		end
		push16(s.ethertype);
		frame_bytes.push_back(s.ver_ihl);
		push_rand(8);
		frame_bytes.push_back(s.proto);
		push_rand(10);
		if (s.ver_ihl[3:0] > IP_IHL_MIN) push_rand((s.ver_ihl[3:0] - IP_IHL_MIN) * 4);
		push16(s.src_port);
		push16(s.dst_port);
		push_rand(4);
		frame_bytes.push_back(s.gtp_flags);
		frame_bytes.push_back(s.gtp_msg);
		push_rand(6);
		if ((s.gtp_flags & GTP_OPT_FLAGS) != 0) begin
			push_rand(3);
			frame_bytes.push_back(s.ext_next);
			if ((s.gtp_flags & GTP_E_FLAG) != 0 && s.ext_next != 0) begin
				for (int k = 0; k < s.ext_count; k++) begin
					words = (s.ext_words > 0) ? s.ext_words : $urandom_range(1, 3);
					frame_bytes.push_back(8'(words));
					push_rand(words * 4 - 2);
					frame_bytes.push_back((k == s.ext_count - 1 && !s.ext_zero_end) ? 8'h00 :
						8'($urandom_range(1, 255)));
				end
				// a zero length byte closes the chain
				if (s.ext_zero_end) frame_bytes.push_back(8'h00);
			end
		end
		frame_bytes.push_back(s.inner_first);
		push_rand(19 + s.payload_len);
		if (s.cut_len > 0)
			while (frame_bytes.size() > s.cut_len) void'(frame_bytes.pop_back());
		if (s.flip_at >= 0 && s.flip_at < frame_bytes.size())
			frame_bytes[s.flip_at] = 8'($urandom_range(0, 255));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (idling && $urandom_range(0, 9) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= fin;
		do @(posedge clk); while (!byte_ch.ready);
		tracker.take_word(b, fin);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// hold the sender until every owed word is back, then let the pipeline settle
	task automatic drain(input int settle);
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.verdicts_due.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		write_reg(REG_GTPU_UDP_PORT, c.gtpu_udp_port);
		write_reg(REG_VLAN_TPID_A, c.vlan_tpid_a);
		write_reg(REG_VLAN_TPID_B, c.vlan_tpid_b);
		write_reg(REG_VLAN_TPID_C, c.vlan_tpid_c);
		wr_en <= 1'b0;
		tracker.regs = c;
		@(posedge clk);
	endtask

	task automatic directed_frames();
		frame_spec_t s;
		for (int d = 0; d < 20; d++) begin
			s = well_formed();
			idling = $urandom_range(0, 1);
			s.vlan_tags = 0;
			s.ver_ihl = 8'h45;
			s.inner_first = 8'h45;
			s.payload_len = 0;
			case (d)
				0: s.gtp_flags = 8'h30;
				1: begin
					// s flag only, the next-type byte must be ignored
					s.vlan_tags = 3;
					s.src_port = tracker.regs.gtpu_udp_port;
					s.gtp_flags = 8'h32;
					s.ext_next = 8'hc0;
					s.inner_first = 8'h60;
				end
				2: s.ver_ihl = 8'h65;
				3: s.ver_ihl = 8'h44;
				4: s.ver_ihl = 8'h4f;
				5: s.proto = 8'h06;
				6: begin
					s.src_port = tracker.regs.gtpu_udp_port ^ 16'h0001;
					s.dst_port = tracker.regs.gtpu_udp_port ^ 16'h8000;
				end
				7: s.gtp_flags = 8'h20;
				8: s.gtp_msg = 8'h01;
				9: begin
					s.gtp_flags = 8'h34;
					s.ext_next = 8'h85;
					s.ext_count = 3;
					s.ext_zero_end = 1'b0;
				end
				10: begin
					s.gtp_flags = 8'h37;
					s.ext_next = 8'h85;
					s.ext_count = 1;
					s.ext_zero_end = 1'b1;
				end
				11: begin
					s.gtp_flags = 8'h34;
					s.ext_next = 8'h00;
				end
				12: begin
					s.gtp_flags = 8'h34;
					s.ext_next = 8'hff;
					s.ext_count = 2;
					s.ext_words = 8;
					s.ext_zero_end = 1'b0;
				end
				13: s.inner_first = 8'h50;
				14: s.ethertype = 16'h86dd;
				15: begin
					s.vlan_tags = 1;
					s.cut_len = 14;
				end
				16: s.noise_len = 1;
				17: begin
					s.gtp_flags = 8'h30;
					s.cut_len = 60;
				end
				18: begin
					s.noise_len = 70;
					s.noise_fill = 8'hff;
				end
				19: begin
					s.noise_len = 70;
					s.noise_fill = 8'h00;
				end
				default: ;
			endcase
			build_frame(s);
			send_frame();
		end
	endtask

	task automatic random_frames(input int min_bytes, input int min_frames);
		int sent_bytes;
		int sent_frames;
		sent_bytes = 0;
		sent_frames = 0;
		while (sent_bytes < min_bytes || sent_frames < min_frames) begin
			if (!final_stretch) idling = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 11) == 0) drain(0);
			build_frame(random_spec());
			send_frame();
			sent_bytes += frame_bytes.size();
			sent_frames++;
		end
	endtask

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.last_byte = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_GTPU_UDP_PORT;
		wr_data = '0;
		idling = 1'b0;
		final_stretch = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		c = '{RST_GTPU_UDP_PORT, RST_VLAN_TPID_A, RST_VLAN_TPID_B, RST_VLAN_TPID_C};
		program_regs(c);
		directed_frames();

		for (int p = 1; p <= 4; p++) begin
			drain(6);
			case (p)
				1: c = '{16'hffff, 16'h0000, 16'hffff, 16'h0000};
				2: c = '{16'h0000, 16'hffff, ETH_TYPE_IPV4, 16'hffff};
				3: c = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
				default: begin
					c = '{16'($urandom), RST_VLAN_TPID_A, RST_VLAN_TPID_B, RST_VLAN_TPID_C};
					final_stretch = 1'b1;
					idling = 1'b0;
				end
			endcase
			program_regs(c);
			random_frames(40, 1);
		end

		drain(8);
		if (tracker.errors == 0 && tracker.verdicts_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/gifl_pkg.sv
rtl/gifl_if.sv
rtl/gifl_cfg_regs.sv
rtl/gifl_parser.sv
rtl/gtpu_inner_frame_locator_top.sv
test/tb_gtpu_inner_frame_locator_top.sv
